[hw/rtl/cursor_sequence_buffer_core_defines.svh]
// ----------------------------------------------------------------------------
// Cursor sequence buffer assertion macros
// Clocked assertion helpers shared by the buffer's RTL files.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_BUFFER_CORE_DEFINES_SVH
`define CURSOR_SEQUENCE_BUFFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define CSB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define CSB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CSB_ASSERT(name, prop, msg)
`define CSB_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[hw/rtl/csb_pkg.sv]
// ----------------------------------------------------------------------------
// Cursor sequence buffer package
// Opcodes, status codes, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;  // value + count, padded to bytes
  localparam int unsigned OUT_TUSER_W = 3;   // present + status

  localparam logic [OPCODE_W-1:0] OP_START   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADVANCE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ATTACH  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_QUERY   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOITEM = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic decide;    // evaluate op, set status, position and move index
    logic shift_rd;  // read neighbor of move index
    logic shift_wr;  // write read data at move index, step index
    logic place;     // write new value, grow count, set cursor
    logic shrink;    // drop count after remove
    logic lookup;    // read slot at cursor
    logic publish;   // load output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic can_grow;    // insert/attach with room
    logic can_shrink;  // remove with a current item
    logic more;        // slots left to move
    logic up;          // move direction is toward the end
    logic out_free;    // output register can take a word
  } sts_t;

endpackage

[hw/rtl/csb_ctrl.sv]
// ----------------------------------------------------------------------------
// Cursor sequence buffer controller
// One-hot sequencer: accept, decide, move slots one by one, look up, publish.
// ----------------------------------------------------------------------------
`include "cursor_sequence_buffer_core_defines.svh"

module csb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  csb_pkg::sts_t sts_i,
  output csb_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECIDE   = 6'b000010,
    S_MOVE     = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_LOOKUP   = 6'b010000,
    S_RESULT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = (sts_i.can_grow || sts_i.can_shrink) ? S_MOVE : S_LOOKUP;
      end
      S_MOVE: begin
        if (sts_i.more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end else begin
          cmd_o.place  = sts_i.up;
          cmd_o.shrink = !sts_i.up;
          state_d      = S_LOOKUP;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_MOVE;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a shift write always uses the data fetched the cycle before
  `CSB_ASSERT(a_wr_after_rd, cmd_o.shift_wr |-> $past(cmd_o.shift_rd), "shift write without read")
  // no new word taken while an item is in flight
  `CSB_ASSERT(a_load_idle, cmd_o.load |=> !in_ready_o, "input taken twice in a row")

endmodule

[hw/rtl/csb_dpath.sv]
// ----------------------------------------------------------------------------
// Cursor sequence buffer datapath
// Slot memory, count and cursor registers, move index and output register.
// ----------------------------------------------------------------------------
`include "cursor_sequence_buffer_core_defines.svh"

module csb_dpath #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  csb_pkg::cmd_t                    cmd_i,
  output csb_pkg::sts_t                    sts_o,
  input  logic [csb_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic [csb_pkg::VALUE_W-1:0]      entry_value_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [csb_pkg::VALUE_W-1:0]      current_value_o,
  output logic                             item_present_o,
  output logic [csb_pkg::COUNT_W-1:0]      item_count_o,
  output logic [csb_pkg::STATUS_W-1:0]     status_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [csb_pkg::OPCODE_W-1:0] op_q;
  logic [DATA_WIDTH-1:0]        val_q;
  logic [DATA_WIDTH-1:0]        rd_q;
  logic [CNT_W-1:0]             fill_q, fill_d;
  logic [CNT_W-1:0]             cur_q, cur_d;
  logic [CNT_W-1:0]             pos_q;
  logic [CNT_W-1:0]             idx_q;
  logic                         up_q;
  logic [csb_pkg::STATUS_W-1:0] status_q;
  logic                         out_valid_q, out_valid_d;
  logic [csb_pkg::VALUE_W-1:0]  value_q;
  logic                         present_q;
  logic [csb_pkg::COUNT_W-1:0]  count_q;
  logic [csb_pkg::STATUS_W-1:0] res_status_q;

  logic                         has_item, full, is_wr, is_rm;
  logic [CNT_W-1:0]             pos_new, idx_up, idx_dn, cur_inc, rd_sel, wr_sel;
  logic [CNT_W:0]               idx_nxt_w;
  logic [csb_pkg::STATUS_W-1:0] status_new;
  logic                         wr_en;
  logic [DATA_WIDTH-1:0]        wr_data;
  logic [63:0]                  in_w, rd_w, fill_w;

  assign has_item = cur_q < fill_q;
  assign full     = fill_q == CNT_W'(CAPACITY);
  assign is_wr    = (op_q == csb_pkg::OP_INSERT) || (op_q == csb_pkg::OP_ATTACH);
  assign is_rm    = op_q == csb_pkg::OP_REMOVE;
  assign cur_inc  = cur_q + CNT_W'(1);
  assign idx_up   = idx_q - CNT_W'(1);
  assign idx_dn   = idx_q + CNT_W'(1);
  assign idx_nxt_w = {1'b0, idx_q} + (CNT_W + 1)'(1);

  always_comb begin
    if (op_q == csb_pkg::OP_INSERT) begin
      pos_new = has_item ? cur_q : '0;
    end else begin
      pos_new = has_item ? cur_inc : fill_q;
    end
  end

  always_comb begin
    if (is_wr && full) begin
      status_new = csb_pkg::ST_FULL;
    end else if (is_rm && !has_item) begin
      status_new = csb_pkg::ST_NOITEM;
    end else begin
      status_new = csb_pkg::ST_OK;
    end
  end

  assign sts_o.can_grow   = is_wr && !full;
  assign sts_o.can_shrink = is_rm && has_item;
  assign sts_o.more       = up_q ? (idx_q > pos_q) : (idx_nxt_w < {1'b0, fill_q});
  assign sts_o.up         = up_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // one read address, one write address per cycle
  assign rd_sel  = cmd_i.shift_rd ? (up_q ? idx_up : idx_dn) : cur_q;
  assign wr_en   = cmd_i.shift_wr || cmd_i.place;
  assign wr_sel  = cmd_i.place ? pos_q : idx_q;
  assign wr_data = cmd_i.place ? val_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_sel[IDX_W-1:0]] <= wr_data;
    end
    if (cmd_i.shift_rd || cmd_i.lookup) begin
      rd_q <= mem[rd_sel[IDX_W-1:0]];
    end
  end

  always_comb begin
    fill_d = fill_q;
    cur_d  = cur_q;
    if (cmd_i.decide) begin
      case (op_q)
        csb_pkg::OP_START:   cur_d = '0;
        csb_pkg::OP_ADVANCE: cur_d = has_item ? cur_inc : fill_q;
        csb_pkg::OP_QUERY:   cur_d = cur_q;
        default:             cur_d = cur_q;
      endcase
    end
    if (cmd_i.place) begin
      fill_d = fill_q + CNT_W'(1);
      cur_d  = pos_q;
    end
    if (cmd_i.shrink) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_w   = 64'(entry_value_i);
  assign rd_w   = 64'(rd_q);
  assign fill_w = 64'(fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= in_w[DATA_WIDTH-1:0];
    end
    if (cmd_i.decide) begin
      status_q <= status_new;
      up_q     <= is_wr;
      pos_q    <= pos_new;
      idx_q    <= is_wr ? fill_q : cur_q;
    end
    if (cmd_i.shift_wr) begin
      idx_q <= up_q ? idx_up : idx_dn;
    end
    if (cmd_i.publish) begin
      value_q      <= has_item ? rd_w[csb_pkg::VALUE_W-1:0] : '0;
      present_q    <= has_item;
      count_q      <= fill_w[csb_pkg::COUNT_W-1:0];
      res_status_q <= status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_value_o = value_q;
  assign item_present_o  = present_q;
  assign item_count_o    = count_q;
  assign status_o        = res_status_q;

  `CSB_ASSERT(a_cur_le_fill, cur_q <= fill_q, "cursor beyond fill count")
  `CSB_ASSERT(a_fill_cap, fill_q <= CNT_W'(CAPACITY), "fill count beyond capacity")
  `CSB_ASSERT(a_place_pos, cmd_i.place |-> (pos_q <= fill_q) && !full, "bad insert position")

endmodule

[hw/rtl/cursor_sequence_buffer_core.sv]
// ----------------------------------------------------------------------------
// Cursor sequence buffer core
// Ordered store of up to CAPACITY values with a cursor, stream in / stream out.
// ----------------------------------------------------------------------------
// Usage: each input word carries an opcode (tuser) and a value (tdata). Every
// accepted word yields exactly one result word: value at the cursor, present
// flag, item count and status.
// Input channel s_axis: taken one word at a time; tready is high only while
// the sequencer is idle.
// Output channel m_axis: a registered output word. The next input word is
// accepted while a result still waits; a stalled receiver only holds the
// sequencer at its publish step.
// Flow: start, advance, query, rejected writes and removes with no item pass
// through decide, slot read and publish before m_axis_tvalid rises, and tready
// returns in the same cycle as m_axis_tvalid rises. Insert, attach and remove
// also pass through the move steps, where every shifted slot costs a read and
// a write on the slot memory; a new input word is taken only after the
// previous one has been published.
// Reset: count and cursor clear, output empty; slot contents are not cleared
// (only written slots are ever reported).
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [csb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] entry_value
  input  logic [csb_pkg::OPCODE_W-1:0]    s_axis_tuser,   // [2:0] opcode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [csb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] current_value,
                                                          // [37:32] item_count
  output logic [csb_pkg::OUT_TUSER_W-1:0] m_axis_tuser    // [0] item_present,
                                                          // [2:1] status
);

  csb_pkg::cmd_t cmd;
  csb_pkg::sts_t sts;

  logic [csb_pkg::VALUE_W-1:0]  current_value;
  logic                         item_present;
  logic [csb_pkg::COUNT_W-1:0]  item_count;
  logic [csb_pkg::STATUS_W-1:0] status;

  csb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csb_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (s_axis_tuser),
    .entry_value_i   (s_axis_tdata),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .current_value_o (current_value),
    .item_present_o  (item_present),
    .item_count_o    (item_count),
    .status_o        (status)
  );

  // pack result word; upper tdata bits pad to a whole byte
  assign m_axis_tdata = {2'b00, item_count, current_value};
  assign m_axis_tuser = {status, item_present};

endmodule

[tb/cursor_sequence_buffer_core_checker.sv]
// ----------------------------------------------------------------------------
// Cursor sequence buffer checker
// Watches both stream channels and keeps a shadow copy of the store and cursor.
// Each input word yields one awaited result view. Each output word is checked
// field by field against the oldest awaited view.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core_checker #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [csb_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [csb_pkg::OPCODE_W-1:0]    s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [csb_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [csb_pkg::OUT_TUSER_W-1:0] m_tuser_i,
  output int unsigned                     fault_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o,
  output int unsigned                     full_hits_o,
  output int unsigned                     noitem_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import csb_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0]  current_value;
    logic                item_present;
    logic [COUNT_W-1:0]  item_count;
    logic [STATUS_W-1:0] status;
  } cursor_view_t;

  logic [DATA_WIDTH-1:0] slot_copy [CAPACITY];
  int unsigned           fill_level;
  int unsigned           cursor_pos;
  cursor_view_t          awaited_views [$];

  // Shadow of one operation; returns the view the block must report.
  function automatic cursor_view_t apply_word(input logic [OPCODE_W-1:0] op,
                                              input logic [VALUE_W-1:0]  val);
    cursor_view_t view;
    int unsigned  pos;
    int unsigned  i;
    view        = '0;
    view.status = ST_OK;
    case (op)
      OP_START: begin
        cursor_pos = 0;
      end
      OP_ADVANCE: begin
        if (cursor_pos < fill_level) cursor_pos++;
      end
      OP_INSERT, OP_ATTACH: begin
        if (fill_level >= CAPACITY) begin
          view.status = ST_FULL;
        end else begin
          if (op == OP_INSERT) pos = (cursor_pos < fill_level) ? cursor_pos : 0;
          else                 pos = (cursor_pos < fill_level) ? cursor_pos + 1 : fill_level;
          for (i = fill_level; i > pos; i--) slot_copy[i] = slot_copy[i-1];
          slot_copy[pos] = DATA_WIDTH'(val);
          fill_level++;
          cursor_pos = pos;
        end
      end
      OP_REMOVE: begin
        if (cursor_pos >= fill_level) begin
          view.status = ST_NOITEM;
        end else begin
          for (i = cursor_pos; i + 1 < fill_level; i++) slot_copy[i] = slot_copy[i+1];
          fill_level--;
        end
      end
      default: ;  // query and spare codes leave everything alone
    endcase
    if (cursor_pos < fill_level) begin
      view.current_value = VALUE_W'(slot_copy[cursor_pos]);
      view.item_present  = 1'b1;
    end
    view.item_count = COUNT_W'(fill_level);
    return view;
  endfunction

  task automatic note_fault(input string what, input longint unsigned want,
                            input longint unsigned got);
    fault_count_o++;
    if (fault_count_o <= 10)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_view_t want;
    cursor_view_t got;
    if (!rst_ni) begin
      fill_level = 0;
      cursor_pos = 0;
      awaited_views.delete();
      pending_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.current_value = m_tdata_i[VALUE_W-1:0];
        got.item_count    = m_tdata_i[VALUE_W +: COUNT_W];
        got.item_present  = m_tuser_i[0];
        got.status        = m_tuser_i[1 +: STATUS_W];
        if (awaited_views.size() == 0) begin
          note_fault("result word with none awaited", 0, m_tdata_i);
        end else begin
          want = awaited_views.pop_front();
          checked_o++;
          if (got.status == ST_FULL)   full_hits_o++;
          if (got.status == ST_NOITEM) noitem_hits_o++;
          if (got.current_value !== want.current_value)
            note_fault("current_value", want.current_value, got.current_value);
          if (got.item_present !== want.item_present)
            note_fault("item_present", want.item_present, got.item_present);
          if (got.item_count !== want.item_count)
            note_fault("item_count", want.item_count, got.item_count);
          if (got.status !== want.status)
            note_fault("status", want.status, got.status);
        end
      end
      if (s_tvalid_i && s_tready_i)
        awaited_views.push_back(apply_word(s_tuser_i, s_tdata_i[VALUE_W-1:0]));
      pending_o = awaited_views.size();
    end
  end

endmodule

[tb/cursor_sequence_buffer_core_tb.sv]
// ----------------------------------------------------------------------------
// Cursor sequence buffer testbench
// Drives opcode/value words into the buffer with random gaps and back-pressure;
// a short directed run hits the edge cases, then grow, drain and mixed phases
// push the store to full and back to empty. The checker judges every result.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csb_pkg::*;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned DRAIN_CYCLES = 100;  // longer than a full-store shift

  // Opcodes the block must treat as a plain query
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {PH_GROW, PH_DRAIN, PH_MIX} phase_e;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [OPCODE_W-1:0]    s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  int unsigned fault_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_hits;
  int unsigned noitem_hits;

  int unsigned words_sent;
  int unsigned directed_words;
  logic        send_quiet;  // no gaps between input words
  logic        recv_quiet;  // no stalls on the output side

  always #6 clk_i = ~clk_i;

  cursor_sequence_buffer_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [31:0] entry_value
    .s_axis_tuser  (s_tuser),   // [2:0] opcode
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [31:0] current_value, [37:32] item_count
    .m_axis_tuser  (m_tuser)    // [0] item_present, [2:1] status
  );

  cursor_sequence_buffer_core_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .fault_count_o (fault_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_hits_o   (full_hits),
    .noitem_hits_o (noitem_hits)
  );

  // Present one word after a random gap and hold it until taken.
  // Entered and left at a falling edge, so valid is touched once per step.
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [31:0] val);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    // values read right after the edge are the ones the block saw
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Opcode mix per phase: grow fills the store toward full, drain empties it
  // mostly with removes and cursor moves, mix draws any code including the spares.
  function automatic logic [OPCODE_W-1:0] pick_op(input phase_e phase);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PH_GROW: begin
        if      (roll < 45) return OP_INSERT;
        else if (roll < 80) return OP_ATTACH;
        else if (roll < 90) return OP_ADVANCE;
        else if (roll < 95) return OP_START;
        else                return OP_QUERY;
      end
      PH_DRAIN: begin
        if      (roll < 40) return OP_REMOVE;
        else if (roll < 65) return OP_ADVANCE;
        else if (roll < 80) return OP_START;
        else if (roll < 90) return OP_INSERT;
        else                return OP_ATTACH;
      end
      default: return OPCODE_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)  return '0;
    if (roll < 10) return '1;
    return $urandom;
  endfunction

  // Output side: random stall before every result, with quiet stretches.
  initial begin
    int unsigned stall;
    int unsigned taken;
    m_tready   = 1'b0;
    recv_quiet = 1'b0;
    taken      = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      @(negedge clk_i);
      taken++;
      if (taken % 40 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // Stimulus and verdict
  initial begin
    phase_e      phase;
    int unsigned run_len;
    int unsigned roll;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_QUERY;
    send_quiet = 1'b0;
    words_sent = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store: every cursor op and a remove with nothing there
    send_word(OP_QUERY,    32'hFFFF_FFFF);
    send_word(OP_START,    32'h0);
    send_word(OP_ADVANCE,  32'h0);
    send_word(OP_REMOVE,   32'h0);
    send_word(OP_SPARE_LO, 32'hDEAD_BEEF);
    send_word(OP_SPARE_HI, 32'h0);
    // Insert into empty lands at the front, attach goes after the current item
    send_word(OP_INSERT,   32'h0000_0000);
    send_word(OP_ATTACH,   32'hFFFF_FFFF);
    send_word(OP_ATTACH,   32'hA5A5_A5A5);
    send_word(OP_START,    32'h0);
    send_word(OP_INSERT,   32'h5A5A_5A5A);
    // Walk off the end, then push past it once more
    send_word(OP_ADVANCE,  32'h0);
    send_word(OP_ADVANCE,  32'h0);
    send_word(OP_ADVANCE,  32'h0);
    send_word(OP_ADVANCE,  32'h0);
    send_word(OP_ADVANCE,  32'h0);
    send_word(OP_REMOVE,   32'h0);
    send_word(OP_INSERT,   32'h8000_0001);
    send_word(OP_ATTACH,   32'h1234_5678);
    // Remove from the middle closes the gap
    send_word(OP_START,    32'h0);
    send_word(OP_ADVANCE,  32'h0);
    send_word(OP_REMOVE,   32'h0);
    send_word(OP_REMOVE,   32'h0);
    send_word(OP_QUERY,    32'h0);
    directed_words = words_sent;

    // Random phases; long grow runs can reach the full store
    while (words_sent < directed_words + RANDOM_WORDS) begin
      roll = $urandom_range(0, 9);
      if      (roll < 4) phase = PH_GROW;
      else if (roll < 8) phase = PH_DRAIN;
      else               phase = PH_MIX;
      run_len    = $urandom_range(20, 70);
      send_quiet = ($urandom_range(0, 3) == 0);
      repeat (run_len) send_word(pick_op(phase), pick_value());
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d directed), checked %0d results.",
             words_sent, directed_words, checked);
    $display("Saw %0d writes refused on a full store and %0d removes with no item.",
             full_hits, noitem_hits);
    if (fault_count == 0 && pending == 0) begin
      $display("cursor_sequence_buffer_core_tb passed");
    end else begin
      $display("cursor_sequence_buffer_core_tb failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #6ms;
    $display("cursor_sequence_buffer_core_tb failed");
    $finish;
  end

endmodule
